/* hw/rtl/interaction_pair_table_unit_assert.svh */
// ----------------------------------------------------------------------------
// Interaction pair table assertion macros
// Short forms for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef INTERACTION_PAIR_TABLE_UNIT_ASSERT_SVH
`define INTERACTION_PAIR_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define IPT_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ipt assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define IPT_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ipt assertion failed");

`endif

/* hw/rtl/ipt_pkg.sv */
// ----------------------------------------------------------------------------
// Interaction pair table package
// Sizes, derived widths, operation and status codes shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ipt_pkg;

	localparam int unsigned TABLE_ROWS   = 64;
	localparam int unsigned MAX_PARTNERS = 8;
	localparam int unsigned ID_BITS      = 32;

	// ids arrive on 32-bit ports; compare only the low ID_BITS of them
	localparam int unsigned ID_W   = (ID_BITS < 32) ? ID_BITS : 32;
	localparam int unsigned ROW_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_PARTNERS + 1);
	localparam int unsigned PTR_W  = (TABLE_ROWS * MAX_PARTNERS > 1) ?
		$clog2(TABLE_ROWS * MAX_PARTNERS) : 1;

	localparam logic [1:0] MODE_RECORD = 2'd0;
	localparam logic [1:0] MODE_CHECK  = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_ROW    = 2'd1;
	localparam logic [1:0] ST_LIST_FULL = 2'd2;

	typedef logic [ID_W-1:0]  id_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ROW_W-1:0] row_idx_t;
	typedef logic [PTR_W-1:0] ptr_idx_t;

	typedef struct packed {
		id_t  key;
		cnt_t cnt;
	} row_word_t;

endpackage

`default_nettype wire

/* hw/rtl/interaction_pair_table_unit.sv */
// ----------------------------------------------------------------------------
// Interaction pair table unit
// Records which particle pairs have interacted and answers pair lookups.
// ----------------------------------------------------------------------------
// One transaction on the input channel carries a mode (record, check, clear)
// and two particle ids; each yields exactly one result transaction with found
// and status. The table has TABLE_ROWS rows, each a key id plus an ordered
// partner list of up to MAX_PARTNERS ids, held in two single-port-read
// memories (key/count per row, partner ids per slot). Row valid marks live in
// flops, so clear drops every row at once and no clearing pass runs after
// reset. A record walks the key memory one row per cycle and stops early at
// the first row keyed by either id; a check always walks all rows, then walks
// the partner lists of the rows keyed by either id, one slot per cycle, and
// stops at the first match. Clear and the unused mode go straight to the
// result. The one key-memory read port and the one partner-memory read port
// pace these walks. The unit takes one transaction at a time: in_ready is
// high only while the sequencer is idle. A result sits in an output register,
// so the next transaction is accepted while an earlier result still waits on
// out_ready; the sequencer holds the new result until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module interaction_pair_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] first_id,
	input  wire logic [31:0] second_id,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [1:0]       status
);

	import ipt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROW,
		S_LIST,
		S_DONE
	} state_t;

	// Row and slot memories; contents are undefined until written
	row_word_t row_mem [TABLE_ROWS];
	id_t       ptr_mem [TABLE_ROWS * MAX_PARTNERS];

	state_t               state_q;
	logic [1:0]           mode_q;
	id_t                  a_q;
	id_t                  b_q;
	logic [TABLE_ROWS-1:0] used_q;

	// Row walk: issue counter and the registered read stage
	logic [ROW_W:0] row_iss_q;
	logic           rd_vld_s1;
	logic           rd_used_s1;
	row_idx_t       rd_row_s1;
	row_word_t      rd_word_s1;

	// Lowest free row and the rows keyed by each id
	logic     free_hit_q;
	row_idx_t free_row_q;
	logic     ha_q;
	row_idx_t ra_q;
	cnt_t     ca_q;
	logic     hb_q;
	row_idx_t rb_q;
	cnt_t     cb_q;

	// Partner list walk
	row_idx_t list_row_q;
	cnt_t     list_cnt_q;
	cnt_t     list_iss_q;
	id_t      list_tgt_q;
	logic     list_phase_b_q;
	logic     pv_s1;
	id_t      pdata_s1;

	// Result waiting for the output register, and the output register
	logic       res_found_q;
	logic [1:0] res_status_q;
	logic       out_valid_q;
	logic       found_q;
	logic [1:0] status_q;

	// Combinational controls
	logic      row_issue;
	row_idx_t  row_rd_idx;
	logic      ev;
	cnt_t      ev_cnt;
	logic      hit_a;
	logic      hit_b;
	logic      rec_hit;
	logic      scan_end;
	logic      list_issue;
	ptr_idx_t  ptr_rd_idx;
	logic      lhit;
	logic      lend;
	logic      row_we;
	row_idx_t  row_wr_idx;
	row_word_t row_wr_data;
	logic      ptr_we;
	ptr_idx_t  ptr_wr_idx;
	id_t       ptr_wr_data;

	// Flat slot address of a row's partner slot
	function automatic ptr_idx_t ptr_addr(input row_idx_t r, input cnt_t k);
		ptr_addr = PTR_W'(r) * PTR_W'(MAX_PARTNERS) + PTR_W'(k);
	endfunction

	always_comb begin
		row_issue  = (state_q == S_ROW) && (row_iss_q < (ROW_W + 1)'(TABLE_ROWS));
		row_rd_idx = row_iss_q[ROW_W-1:0];

		// Evaluate the row read issued in the previous cycle
		ev     = (state_q == S_ROW) && rd_vld_s1;
		ev_cnt = (rd_word_s1.cnt > CNT_W'(MAX_PARTNERS)) ?
			CNT_W'(MAX_PARTNERS) : rd_word_s1.cnt;
		hit_a  = ev && rd_used_s1 && (rd_word_s1.key == a_q);
		hit_b  = ev && rd_used_s1 && (rd_word_s1.key == b_q);
		rec_hit  = (mode_q == MODE_RECORD) && (hit_a || hit_b);
		scan_end = (state_q == S_ROW) && !rd_vld_s1 && !row_issue;

		list_issue = (state_q == S_LIST) && (list_iss_q < list_cnt_q);
		ptr_rd_idx = ptr_addr(list_row_q, list_iss_q);
		lhit = (state_q == S_LIST) && pv_s1 && (pdata_s1 == list_tgt_q);
		lend = (state_q == S_LIST) && !pv_s1 && !list_issue;

		row_we      = 1'b0;
		row_wr_idx  = rd_row_s1;
		row_wr_data = rd_word_s1;
		ptr_we      = 1'b0;
		ptr_wr_idx  = ptr_addr(rd_row_s1, ev_cnt);
		ptr_wr_data = hit_a ? b_q : a_q;

		if (rec_hit) begin
			// Append the other id to the first matching row, unless full
			if (ev_cnt < CNT_W'(MAX_PARTNERS)) begin
				row_we          = 1'b1;
				row_wr_data.cnt = ev_cnt + cnt_t'(1);
				ptr_we          = 1'b1;
			end
		end else if (scan_end && (mode_q == MODE_RECORD) && free_hit_q) begin
			// Open the lowest free row with first id as key
			row_we          = 1'b1;
			row_wr_idx      = free_row_q;
			row_wr_data.key = a_q;
			row_wr_data.cnt = cnt_t'(1);
			ptr_we          = 1'b1;
			ptr_wr_idx      = ptr_addr(free_row_q, cnt_t'(0));
			ptr_wr_data     = b_q;
		end
	end

	// Key/count memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_wr_idx] <= row_wr_data;
		end
		rd_word_s1 <= row_mem[row_rd_idx];
		rd_row_s1  <= row_rd_idx;
	end

	// Partner memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[ptr_wr_idx] <= ptr_wr_data;
		end
		pdata_s1 <= ptr_mem[ptr_rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mode_q         <= MODE_RECORD;
			a_q            <= '0;
			b_q            <= '0;
			used_q         <= '0;
			row_iss_q      <= '0;
			rd_vld_s1      <= 1'b0;
			rd_used_s1     <= 1'b0;
			free_hit_q     <= 1'b0;
			free_row_q     <= '0;
			ha_q           <= 1'b0;
			ra_q           <= '0;
			ca_q           <= '0;
			hb_q           <= 1'b0;
			rb_q           <= '0;
			cb_q           <= '0;
			list_row_q     <= '0;
			list_cnt_q     <= '0;
			list_iss_q     <= '0;
			list_tgt_q     <= '0;
			list_phase_b_q <= 1'b0;
			pv_s1          <= 1'b0;
			res_found_q    <= 1'b0;
			res_status_q   <= ST_OK;
			out_valid_q    <= 1'b0;
			found_q        <= 1'b0;
			status_q       <= ST_OK;
		end else begin
			rd_vld_s1  <= row_issue;
			rd_used_s1 <= used_q[row_rd_idx];
			pv_s1      <= list_issue;
			if (row_issue) begin
				row_iss_q <= row_iss_q + (ROW_W + 1)'(1);
			end
			if (list_issue) begin
				list_iss_q <= list_iss_q + cnt_t'(1);
			end
			// drop a taken result; in S_DONE the register reloads instead
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q       <= mode;
						a_q          <= first_id[ID_W-1:0];
						b_q          <= second_id[ID_W-1:0];
						row_iss_q    <= '0;
						free_hit_q   <= 1'b0;
						ha_q         <= 1'b0;
						hb_q         <= 1'b0;
						res_found_q  <= 1'b0;
						res_status_q <= ST_OK;
						unique case (mode) inside
							MODE_RECORD, MODE_CHECK: begin
								state_q <= S_ROW;
							end
							MODE_CLEAR: begin
								// drop every row at once
								used_q  <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_ROW: begin
					if (ev && !rd_used_s1 && !free_hit_q) begin
						free_hit_q <= 1'b1;
						free_row_q <= rd_row_s1;
					end
					if (hit_a && !ha_q) begin
						ha_q <= 1'b1;
						ra_q <= rd_row_s1;
						ca_q <= ev_cnt;
					end
					if (hit_b && !hb_q) begin
						hb_q <= 1'b1;
						rb_q <= rd_row_s1;
						cb_q <= ev_cnt;
					end
					if (rec_hit) begin
						res_status_q <= (ev_cnt < CNT_W'(MAX_PARTNERS)) ?
							ST_OK : ST_LIST_FULL;
						state_q <= S_DONE;
					end else if (scan_end) begin
						if (mode_q == MODE_RECORD) begin
							if (free_hit_q) begin
								used_q[free_row_q] <= 1'b1;
								res_status_q       <= ST_OK;
							end else begin
								res_status_q <= ST_NO_ROW;
							end
							state_q <= S_DONE;
						end else begin
							// first look for second id in the row keyed by first id
							list_row_q     <= ra_q;
							list_cnt_q     <= ha_q ? ca_q : '0;
							list_tgt_q     <= b_q;
							list_iss_q     <= '0;
							list_phase_b_q <= 1'b0;
							state_q        <= S_LIST;
						end
					end
				end
				S_LIST: begin
					if (lhit) begin
						res_found_q <= 1'b1;
						state_q     <= S_DONE;
					end else if (lend) begin
						if (!list_phase_b_q) begin
							// then the reverse direction
							list_row_q     <= rb_q;
							list_cnt_q     <= hb_q ? cb_q : '0;
							list_tgt_q     <= a_q;
							list_iss_q     <= '0;
							list_phase_b_q <= 1'b1;
						end else begin
							res_found_q <= 1'b0;
							state_q     <= S_DONE;
						end
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						found_q     <= res_found_q;
						status_q    <= res_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign status    = status_q;

endmodule

`default_nettype wire

/* hw/rtl/ipt_checker.sv */
// ----------------------------------------------------------------------------
// Interaction pair table port checker
// Port-level checks on the unit's channels, bound into every instance of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interaction_pair_table_unit_assert.svh"

module ipt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  mode,
	input wire logic [31:0] first_id,
	input wire logic [31:0] second_id,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        found,
	input wire logic [1:0]  status
);

	import ipt_pkg::*;

	logic unused_fields;
	assign unused_fields = ^{mode, first_id, second_id};

	// busy after every accepted transaction
	`IPT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// a stalled result holds
	`IPT_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
		out_valid && $stable(found) && $stable(status))
	// only defined status codes leave the unit
	`IPT_ASSERT_IMPL(a_status_code, out_valid,
		status == ST_OK || status == ST_NO_ROW || status == ST_LIST_FULL)
	// a found pair never comes with an error status
	`IPT_ASSERT_IMPL(a_found_ok, out_valid && found, status == ST_OK)

endmodule

bind interaction_pair_table_unit ipt_checker u_ipt_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Interaction pair table unit testbench
// Drives record, check and clear transactions into the unit with random gaps
// on both channels. A scoreboard keeps its own copy of the pair table, works
// out found and status for every accepted transaction and checks each result
// in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import ipt_pkg::*;

	// The fourth mode code has no function; the unit answers it and moves on.
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int unsigned ITEM_TARGET  = 1850;
	localparam int unsigned LIMIT_CYCLES = 2_000_000;
	// Allow a full check walk after the last result before closing the run.
	localparam int unsigned TAIL_CYCLES  = TABLE_ROWS + 2 * (MAX_PARTNERS + 1) + 40;
	localparam int unsigned POOL_SIZE    = 12;

	typedef struct packed {
		logic       found;
		logic [1:0] status;
	} reply_t;

	// ------------------------------------------------------------------------
	// Scoreboard: shadow pair table plus the queue of replies still owed
	// ------------------------------------------------------------------------
	class pair_table_scoreboard;
		id_t         key_of_row[TABLE_ROWS];
		bit          row_live[TABLE_ROWS];
		id_t         partners_of_row[TABLE_ROWS][MAX_PARTNERS];
		int unsigned partner_total[TABLE_ROWS];
		reply_t      owed_replies[$];
		int unsigned mismatch_count;

		function new();
			mismatch_count = 0;
			empty_table();
		endfunction

		function void empty_table();
			foreach (row_live[r]) begin
				row_live[r]      = 1'b0;
				partner_total[r] = 0;
			end
		endfunction

		function bit row_holds(int r, id_t key, id_t partner);
			if (!row_live[r] || key_of_row[r] != key)
				return 1'b0;
			for (int k = 0; k < partner_total[r]; k++) begin
				if (partners_of_row[r][k] == partner)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		// First live row keyed by either id takes the other id; else open the
		// lowest free row with the first id as key.
		function logic [1:0] add_pair(id_t a, id_t b);
			for (int r = 0; r < TABLE_ROWS; r++) begin
				if (row_live[r] && (key_of_row[r] == a || key_of_row[r] == b)) begin
					if (partner_total[r] >= MAX_PARTNERS)
						return ST_LIST_FULL;
					partners_of_row[r][partner_total[r]] = (key_of_row[r] == a) ? b : a;
					partner_total[r]++;
					return ST_OK;
				end
			end
			for (int r = 0; r < TABLE_ROWS; r++) begin
				if (!row_live[r]) begin
					row_live[r]              = 1'b1;
					key_of_row[r]            = a;
					partners_of_row[r][0]    = b;
					partner_total[r]         = 1;
					return ST_OK;
				end
			end
			return ST_NO_ROW;
		endfunction

		function bit pair_known(id_t a, id_t b);
			for (int r = 0; r < TABLE_ROWS; r++) begin
				if (row_holds(r, a, b) || row_holds(r, b, a))
					return 1'b1;
			end
			return 1'b0;
		endfunction

		// Note one accepted input transaction and queue the reply it owes.
		function void note_transaction(logic [1:0] op, logic [31:0] a_raw, logic [31:0] b_raw);
			reply_t rep;
			id_t    a;
			id_t    b;
			a          = id_t'(a_raw);
			b          = id_t'(b_raw);
			rep.found  = 1'b0;
			rep.status = ST_OK;
			case (op)
				MODE_RECORD: rep.status = add_pair(a, b);
				MODE_CHECK:  rep.found  = pair_known(a, b);
				MODE_CLEAR:  empty_table();
				default: ;
			endcase
			owed_replies.push_back(rep);
		endfunction

		// Compare one accepted result transaction against the oldest reply.
		function void check_result(logic f, logic [1:0] s);
			reply_t rep;
			if (owed_replies.size() == 0) begin
				$error("result with nothing pending: found %0b status %0d", f, s);
				mismatch_count++;
				return;
			end
			rep = owed_replies.pop_front();
			if (f !== rep.found) begin
				$error("found: expected %0b, actual %0b", rep.found, f);
				mismatch_count++;
			end
			if (s !== rep.status) begin
				$error("status: expected %0d, actual %0d", rep.status, s);
				mismatch_count++;
			end
		endfunction

		function int unsigned pending();
			return owed_replies.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and DUT
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [1:0]  mode      = MODE_RECORD;
	logic [31:0] first_id  = '0;
	logic [31:0] second_id = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [1:0]  status;

	pair_table_scoreboard sb = new();

	int unsigned cycle_count = 0;
	int unsigned items_sent  = 0;
	bit          calm        = 1'b0;   // while set, neither side idles
	id_t         id_pool[POOL_SIZE];

	initial begin
		forever #6 clk = ~clk;
	end

	interaction_pair_table_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.first_id  (first_id),
		.second_id (second_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.status    (status)
	);

	// ------------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------------

	// Gap length: mostly none or short, now and then long; none while calm.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Refill the id pool; sometimes seed it with the extreme ids.
	function automatic void refresh_pool();
		foreach (id_pool[i])
			id_pool[i] = id_t'($urandom());
		if ($urandom_range(0, 3) == 0) begin
			id_pool[0] = '0;
			id_pool[1] = '1;
		end
	endfunction

	// Mostly a pool id so pairs repeat; sometimes a fresh random one.
	function automatic logic [31:0] pick_id();
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		return 32'(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
	endfunction

	// Present one input transaction after a random gap; hold it until taken.
	task automatic send_item(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= op;
		first_id  <= a;
		second_id <= b;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_transaction(op, a, b);
		if (op != MODE_SPARE)
			items_sent++;
	endtask

	// Drop valid and hold off until every owed result has come back.
	task automatic wait_table_idle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int unsigned kind;
		int unsigned len;
		logic [31:0] key;

		refresh_pool();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, reverse lookups, equal ids, both ids keyed,
		// a full partner list, the spare mode and clear.
		calm = 1'b1;
		send_item(MODE_CHECK,  32'h0,         32'h0);
		send_item(MODE_RECORD, 32'h0,         32'hFFFF_FFFF);
		send_item(MODE_CHECK,  32'hFFFF_FFFF, 32'h0);
		send_item(MODE_CHECK,  32'h0,         32'hFFFF_FFFF);
		send_item(MODE_RECORD, 32'hFFFF_FFFF, 32'h0);
		send_item(MODE_RECORD, 32'h5,         32'h5);
		send_item(MODE_RECORD, 32'h5,         32'h5);
		send_item(MODE_CHECK,  32'h5,         32'h5);
		send_item(MODE_SPARE,  32'hA5A5_5A5A, 32'h5A5A_A5A5);
		send_item(MODE_RECORD, 32'h0,         32'h5);
		send_item(MODE_RECORD, 32'h5,         32'h0);
		calm = 1'b0;
		send_item(MODE_RECORD, 32'h0,         32'hAAAA_5555);
		send_item(MODE_RECORD, 32'h5555_AAAA, 32'h0);
		send_item(MODE_RECORD, 32'h0,         32'h8000_0000);
		send_item(MODE_RECORD, 32'h0,         32'h7FFF_FFFF);
		send_item(MODE_RECORD, 32'h0,         32'h1234_5678);
		send_item(MODE_CHECK,  32'h5555_AAAA, 32'h0);
		send_item(MODE_CHECK,  32'h0,         32'h1234_5678);
		send_item(MODE_CHECK,  32'h5,         32'h0);
		send_item(MODE_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(MODE_CHECK,  32'h0,         32'hFFFF_FFFF);
		send_item(MODE_RECORD, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(MODE_CHECK,  32'h7FFF_FFFF, 32'h8000_0000);
		wait_table_idle();

		// Random part: short sequences of one flavor each.
		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				// Pool traffic: records and checks over the id pool, a spare now and then.
				len = $urandom_range(8, 30);
				repeat (len) begin
					if ($urandom_range(0, 49) == 0)
						send_item(MODE_SPARE, $urandom(), $urandom());
					else if ($urandom_range(0, 1) == 0)
						send_item(MODE_RECORD, pick_id(), pick_id());
					else
						send_item(MODE_CHECK, pick_id(), pick_id());
				end
			end else if (kind < 65) begin
				// Check burst over the pool, both orders.
				len = $urandom_range(6, 20);
				repeat (len)
					send_item(MODE_CHECK, pick_id(), pick_id());
			end else if (kind < 73) begin
				// Fill: fresh keys past the last row, then mostly clear.
				repeat (TABLE_ROWS + 6)
					send_item(MODE_RECORD, $urandom(), $urandom());
				send_item(MODE_CHECK, pick_id(), pick_id());
				if ($urandom_range(0, 3) != 0)
					send_item(MODE_CLEAR, $urandom(), $urandom());
			end else if (kind < 83) begin
				// Overflow one partner list, then look at it.
				key = pick_id();
				repeat (MAX_PARTNERS + 2) begin
					if ($urandom_range(0, 1) == 0)
						send_item(MODE_RECORD, key, pick_id());
					else
						send_item(MODE_RECORD, pick_id(), key);
				end
				repeat (4)
					send_item(MODE_CHECK, key, pick_id());
			end else if (kind < 95) begin
				// Noise: any mode, any ids.
				len = $urandom_range(4, 16);
				repeat (len)
					send_item(2'($urandom_range(0, 3)), $urandom(), $urandom());
			end else begin
				// Clear and start over with new ids.
				send_item(MODE_CLEAR, $urandom(), $urandom());
				refresh_pool();
			end
			// Now and then let the unit drain completely.
			if ($urandom_range(0, 9) == 0)
				wait_table_idle();
		end

		// Wrap up: drain, then watch for stray results.
		calm = 1'b0;
		wait_table_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("[interaction_pair_table_unit] OK");
		else
			$display("[interaction_pair_table_unit] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: check each accepted transaction, stall at random
	// ------------------------------------------------------------------------
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(found, status);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT_CYCLES) begin
				$display("[interaction_pair_table_unit] ERROR");
				$finish;
			end
		end
	end

endmodule
